>>> hw/rtl/allpass_fractional_delay_line_core_defines.svh
// Shared assertion macros for the fractional delay line.
// Each expects signals named clock and reset in the module that uses it.
`ifndef ALLPASS_FRACTIONAL_DELAY_LINE_CORE_DEFINES_SVH
`define ALLPASS_FRACTIONAL_DELAY_LINE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define AFDL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AFDL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/afdl_pkg.sv
`default_nettype none

package afdl_pkg;

   localparam int MAX_LENGTH    = 4096;
   localparam int ADDR_BITS     = 12;
   localparam int LENGTH_BITS   = 13;
   localparam int SAMPLE_BITS   = 16;
   localparam int FRACTION_BITS = 8;
   localparam int DELAY_BITS    = LENGTH_BITS + FRACTION_BITS;
   localparam int COEF_BITS     = 15;
   localparam int ALPHA_BITS    = FRACTION_BITS + 1;
   localparam int DEN_BITS      = FRACTION_BITS + 2;
   localparam int MAG_BITS      = FRACTION_BITS;
   localparam int NUM_BITS      = MAG_BITS + COEF_BITS;
   localparam int DIV_CNT_BITS  = 4;
   localparam int PROD_BITS     = COEF_BITS + SAMPLE_BITS + 1;
   localparam int SUM_BITS      = SAMPLE_BITS + 2;
   localparam int ONE_VALUE     = 1 << FRACTION_BITS;
   localparam int HALF_VALUE    = ONE_VALUE / 2;
   localparam int ROUND_VALUE   = 1 << (COEF_BITS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POS,
      ST_TAP,
      ST_READ,
      ST_WAIT,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [ALPHA_BITS-1:0] alpha;
   } div_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [COEF_BITS-1:0] coef;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/allpass_fractional_delay_line_core.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_sample_in, req_delay_samples
// rsp      out        rsp_valid/rsp_stall  rsp_sample_out
// csr      in         csr_wr_en            csr_wr_data (line length)
//
// A transaction runs from acceptance through the POS, TAP, READ, WAIT, MUL and
// OUT states to the result register; WAIT lasts until the 15-step restoring
// divider has formed the allpass coefficient. The next transaction is accepted
// in the following cycle at the earliest. After reset a clearing pass zeroes all
// 4096 sample store entries; req_stall stays high during it, csr writes are taken
// at any time. A result waiting under rsp_stall holds the next transaction in OUT.
`default_nettype none

`include "allpass_fractional_delay_line_core_defines.svh"

module allpass_fractional_delay_line_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [afdl_pkg::SAMPLE_BITS-1:0]  req_sample_in,
   input  logic        [afdl_pkg::DELAY_BITS-1:0]   req_delay_samples,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [afdl_pkg::SAMPLE_BITS-1:0]  rsp_sample_out,
   input  logic                                     csr_wr_en,
   input  logic        [afdl_pkg::LENGTH_BITS-1:0]  csr_wr_data
);

   import afdl_pkg::*;

   state_type state_ff;
   state_type state_in;

   logic [ADDR_BITS-1:0]          clr_cnt_ff;
   logic [LENGTH_BITS-1:0]        len_ff;
   logic [ADDR_BITS-1:0]          wp_ff;
   logic [ADDR_BITS-1:0]          wp_eff_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [DELAY_BITS-1:0]         d_ff;
   logic [DELAY_BITS-1:0]         pos_ff;
   logic [ADDR_BITS-1:0]          tapix_ff;
   logic signed [SAMPLE_BITS-1:0] last_ff;
   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;

   logic [LENGTH_BITS-1:0]        csr_len_c;
   logic [DELAY_BITS-1:0]         top_c;
   logic [DELAY_BITS-1:0]         d_clamp_c;
   logic [ADDR_BITS-1:0]          wp_eff_c;
   logic [LENGTH_BITS-1:0]        wp_inc_c;
   logic [DELAY_BITS:0]           pos_diff_c;
   logic [DELAY_BITS:0]           pos_adj_c;
   logic [LENGTH_BITS-1:0]        tap_hi_c;
   logic [LENGTH_BITS-1:0]        tapix0_c;
   logic [LENGTH_BITS-1:0]        tapix_inc_c;
   logic [LENGTH_BITS-1:0]        tapix_c;
   logic [FRACTION_BITS-1:0]      frac_c;
   logic [ALPHA_BITS-1:0]         alpha_base_c;
   logic [ALPHA_BITS-1:0]         alpha_c;
   logic [LENGTH_BITS-1:0]        wp_next_c;
   logic signed [SAMPLE_BITS:0]   diff_c;
   logic signed [PROD_BITS-1:0]   prod_c;
   logic signed [PROD_BITS-1:0]   rnd_sum_c;
   logic signed [SAMPLE_BITS:0]   rnd_c;
   logic signed [SUM_BITS-1:0]    y_wide_c;
   logic signed [SAMPLE_BITS-1:0] y_c;
   logic                          req_fire_c;
   logic                          out_fire_c;

   logic                          mem_wr_en;
   logic [ADDR_BITS-1:0]          mem_wr_addr;
   logic [SAMPLE_BITS-1:0]        mem_wr_data;
   logic                          mem_rd_en;
   logic [SAMPLE_BITS-1:0]        mem_rd_data;
   logic signed [SAMPLE_BITS-1:0] tap_c;

   div_req_type div_req;
   div_rsp_type div_rsp;

   afdl_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_LENGTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (tapix_ff),
      .rd_data (mem_rd_data)
   );

   afdl_coef_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      if (csr_wr_data == '0) begin
         csr_len_c = LENGTH_BITS'(1);
      end else if (csr_wr_data > LENGTH_BITS'(MAX_LENGTH)) begin
         csr_len_c = LENGTH_BITS'(MAX_LENGTH);
      end else begin
         csr_len_c = csr_wr_data;
      end

      top_c = {len_ff, {FRACTION_BITS{1'b0}}};
      if (req_delay_samples < DELAY_BITS'(HALF_VALUE)) begin
         d_clamp_c = DELAY_BITS'(HALF_VALUE);
      end else if (req_delay_samples > top_c) begin
         d_clamp_c = top_c;
      end else begin
         d_clamp_c = req_delay_samples;
      end

      wp_eff_c   = ({1'b0, wp_ff} >= len_ff) ? '0 : wp_ff;
      wp_inc_c   = {1'b0, wp_eff_c} + LENGTH_BITS'(1);
      pos_diff_c = {1'b0, wp_inc_c, {FRACTION_BITS{1'b0}}} - {1'b0, d_ff};
      pos_adj_c  = pos_diff_c[DELAY_BITS] ? pos_diff_c + {1'b0, top_c} : pos_diff_c;

      tap_hi_c     = pos_ff[DELAY_BITS-1:FRACTION_BITS];
      tapix0_c     = (tap_hi_c >= len_ff) ? '0 : tap_hi_c;
      frac_c       = pos_ff[FRACTION_BITS-1:0];
      alpha_base_c = ALPHA_BITS'(ONE_VALUE) - {1'b0, frac_c};
      tapix_inc_c  = tapix0_c + LENGTH_BITS'(1);
      if (alpha_base_c < ALPHA_BITS'(HALF_VALUE)) begin
         tapix_c = (tapix_inc_c >= len_ff) ? tapix_inc_c - len_ff : tapix_inc_c;
         alpha_c = alpha_base_c + ALPHA_BITS'(ONE_VALUE);
      end else begin
         tapix_c = tapix0_c;
         alpha_c = alpha_base_c;
      end

      wp_next_c = {1'b0, wp_eff_ff} + LENGTH_BITS'(1);
      if (wp_next_c >= len_ff) begin
         wp_next_c = '0;
      end

      tap_c  = $signed(mem_rd_data);
      diff_c = {tap_c[SAMPLE_BITS-1], tap_c} - {last_ff[SAMPLE_BITS-1], last_ff};
      prod_c = div_rsp.coef * diff_c;

      rnd_sum_c = prod_ff + PROD_BITS'(ROUND_VALUE);
      rnd_c     = rnd_sum_c[PROD_BITS-1:COEF_BITS];
      y_wide_c  = {{2{prev_ff[SAMPLE_BITS-1]}}, prev_ff} + {rnd_c[SAMPLE_BITS], rnd_c};
      if ((y_wide_c[SUM_BITS-1] == y_wide_c[SUM_BITS-2])
          && (y_wide_c[SUM_BITS-2] == y_wide_c[SAMPLE_BITS-1])) begin
         y_c = y_wide_c[SAMPLE_BITS-1:0];
      end else if (y_wide_c[SUM_BITS-1]) begin
         y_c = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         y_c = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end

      req_fire_c = req_valid && !req_stall;
      out_fire_c = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == ADDR_BITS'(MAX_LENGTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_POS;
            end
         end
         ST_POS:  state_in = ST_TAP;
         ST_TAP:  state_in = ST_READ;
         ST_READ: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_fire_c) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall     = 1'b1;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wp_eff_ff;
      mem_wr_data   = x_ff;
      mem_rd_en     = 1'b0;
      div_req.start = 1'b0;
      div_req.alpha = alpha_c;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: req_stall = 1'b0;
         ST_TAP: begin
            mem_wr_en     = 1'b1;
            div_req.start = 1'b1;
         end
         ST_READ: mem_rd_en = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         len_ff       <= LENGTH_BITS'(MAX_LENGTH);
         wp_ff        <= '0;
         last_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_BITS'(1);
         end
         if (csr_wr_en) begin
            len_ff <= csr_len_c;
         end
         if (state_ff == ST_TAP) begin
            wp_ff <= wp_next_c[ADDR_BITS-1:0];
         end
         if (out_fire_c) begin
            last_ff      <= y_c;
            prev_ff      <= tap_c;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire_c) begin
         x_ff <= req_sample_in;
         d_ff <= d_clamp_c;
      end
      if (state_ff == ST_POS) begin
         pos_ff    <= pos_adj_c[DELAY_BITS-1:0];
         wp_eff_ff <= wp_eff_c;
      end
      if (state_ff == ST_TAP) begin
         tapix_ff <= tapix_c[ADDR_BITS-1:0];
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_c;
      end
      if (out_fire_c) begin
         rsp_data_ff <= y_c;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   `AFDL_ASSERT_SAME(a_alpha_range, state_ff == ST_TAP,
                     alpha_c >= ALPHA_BITS'(HALF_VALUE)
                     && alpha_c <= ALPHA_BITS'(ONE_VALUE + HALF_VALUE),
                     "alpha outside one half to three halves")
   `AFDL_ASSERT_SAME(a_tap_in_line, state_ff == ST_TAP, tapix_c < len_ff,
                     "tap index beyond line length")
   `AFDL_ASSERT_SAME(a_mul_after_div, state_ff == ST_MUL, div_rsp.done,
                     "multiply before coefficient ready")
   `AFDL_ASSERT_SAME(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT,
                     "result raised outside output step")

endmodule

`default_nettype wire

>>> hw/rtl/afdl_ram.sv
`default_nettype none

module afdl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/afdl_coef_div.sv
`default_nettype none

`include "allpass_fractional_delay_line_core_defines.svh"

module afdl_coef_div (
   input  logic                 clock,
   input  logic                 reset,
   input  afdl_pkg::div_req_type div_req,
   output afdl_pkg::div_rsp_type div_rsp
);

   import afdl_pkg::*;

   logic [MAG_BITS-1:0]     mag_c;
   logic [ALPHA_BITS-1:0]   mag_wide_c;
   logic [DEN_BITS-1:0]     den_c;
   logic [NUM_BITS-1:0]     num_c;
   logic [DEN_BITS:0]       rem_sh_c;
   logic                    ge_c;
   logic [DEN_BITS:0]       rem_sub_c;

   logic                    busy_ff;
   logic                    done_ff;
   logic                    neg_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic [DEN_BITS-1:0]     den_ff;
   logic [DEN_BITS-1:0]     rem_ff;
   logic [COEF_BITS-1:0]    low_ff;
   logic [COEF_BITS-1:0]    q_ff;

   always_comb begin
      if (div_req.alpha > ALPHA_BITS'(ONE_VALUE)) begin
         mag_wide_c = div_req.alpha - ALPHA_BITS'(ONE_VALUE);
      end else begin
         mag_wide_c = ALPHA_BITS'(ONE_VALUE) - div_req.alpha;
      end
      mag_c     = mag_wide_c[MAG_BITS-1:0];
      den_c     = DEN_BITS'(ONE_VALUE) + DEN_BITS'(div_req.alpha);
      num_c     = {mag_c, {COEF_BITS{1'b0}}} + NUM_BITS'(den_c[DEN_BITS-1:1]);
      rem_sh_c  = {rem_ff, low_ff[COEF_BITS-1]};
      ge_c      = rem_sh_c >= {1'b0, den_ff};
      rem_sub_c = rem_sh_c - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (div_req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= DIV_CNT_BITS'(COEF_BITS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         neg_ff <= div_req.alpha > ALPHA_BITS'(ONE_VALUE);
         den_ff <= den_c;
         rem_ff <= DEN_BITS'(num_c[NUM_BITS-1:COEF_BITS]);
         low_ff <= num_c[COEF_BITS-1:0];
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge_c ? rem_sub_c[DEN_BITS-1:0] : rem_sh_c[DEN_BITS-1:0];
         low_ff <= {low_ff[COEF_BITS-2:0], 1'b0};
         q_ff   <= {q_ff[COEF_BITS-2:0], ge_c};
      end
   end

   always_comb begin
      div_rsp.done = done_ff;
      div_rsp.coef = neg_ff ? -$signed(q_ff) : $signed(q_ff);
   end

   `AFDL_ASSERT_SAME(a_rem_below_den, busy_ff, rem_ff < den_ff, "divider remainder reached divisor")
   `AFDL_ASSERT_NEXT(a_start_busy, div_req.start, busy_ff && !done_ff, "divider did not start")
   `AFDL_ASSERT_SAME(a_done_idle, done_ff, !busy_ff, "divider done while busy")
   `AFDL_ASSERT_SAME(a_rose_done, $rose(done_ff), $past(busy_ff) && q_ff[COEF_BITS-1] == 1'b0,
                     "coefficient out of range")

endmodule

`default_nettype wire

>>> sim/tb_allpass_fractional_delay_line_core.sv
`default_nettype none

module tb_allpass_fractional_delay_line_core;
   import afdl_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_IDLE     = 11;
   localparam int DRAIN_CYCLES = 30;
   localparam int SHOW_LIMIT   = 10;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic signed [SAMPLE_BITS-1:0]   req_sample_in;
   logic        [DELAY_BITS-1:0]    req_delay_samples;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic signed [SAMPLE_BITS-1:0]   rsp_sample_out;
   logic                            csr_wr_en;
   logic        [LENGTH_BITS-1:0]   csr_wr_data;

   // predictor state
   logic signed [SAMPLE_BITS-1:0]   ring_mem [MAX_LENGTH];
   int                              ring_wr_pos;
   int                              ring_len;
   longint                          last_out;
   longint                          prev_tap;

   logic signed [SAMPLE_BITS-1:0]   expected_samples [$];
   int                              fail_count;
   int                              mismatch_count;
   int                              cycle_count;
   int                              rsp_hold_left;
   bit                              no_idle;

   allpass_fractional_delay_line_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_in     (req_sample_in),
      .req_delay_samples (req_delay_samples),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_out    (rsp_sample_out),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic logic signed [SAMPLE_BITS-1:0] allpass_step(
      input logic signed [SAMPLE_BITS-1:0] x,
      input logic        [DELAY_BITS-1:0]  d_in);
      longint len, wp, d, top, pos, tapix, frac, alpha, den, mag, q, c, tap, y;
      len = longint'(ring_len);
      wp  = longint'(ring_wr_pos);
      d   = longint'(d_in);
      top = len * ONE_VALUE;
      if (wp >= len) wp = 0;
      if (d < HALF_VALUE) d = HALF_VALUE;
      if (d > top) d = top;
      pos = (wp + 1) * ONE_VALUE - d;
      if (pos < 0) pos += top;
      tapix = pos / ONE_VALUE;
      if (tapix >= len) tapix = 0;
      frac  = pos % ONE_VALUE;
      alpha = ONE_VALUE - frac;
      // keep alpha in [0.5, 1.5) by moving the tap one entry on
      if (alpha < HALF_VALUE) begin
         tapix = tapix + 1;
         if (tapix >= len) tapix -= len;
         alpha += ONE_VALUE;
      end
      ring_mem[wp] = x;
      wp = wp + 1;
      if (wp >= len) wp = 0;
      ring_wr_pos = int'(wp);
      tap = longint'(ring_mem[tapix]);
      den = ONE_VALUE + alpha;
      mag = (alpha > ONE_VALUE) ? alpha - ONE_VALUE : ONE_VALUE - alpha;
      q   = ((mag << COEF_BITS) + (den >> 1)) / den;
      c   = (alpha > ONE_VALUE) ? -q : q;
      y   = prev_tap + ((c * (tap - last_out) + ROUND_VALUE) >>> COEF_BITS);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      last_out = y;
      prev_tap = tap;
      return y[SAMPLE_BITS-1:0];
   endfunction

   task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s,
                              input logic        [DELAY_BITS-1:0]  d);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_in     <= s;
      req_delay_samples <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_samples.push_back(allpass_step(s, d));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
   endtask

   task automatic set_line_length(input logic [LENGTH_BITS-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (value == 0) ring_len = 1;
      else if (value > MAX_LENGTH) ring_len = MAX_LENGTH;
      else ring_len = int'(value);
   endtask

   task automatic test_delay_clamps();
      push_sample(16'sh7fff, DELAY_BITS'(0));
      push_sample(16'sh8000, DELAY_BITS'(HALF_VALUE - 1));
      push_sample(-16'sd1, DELAY_BITS'(HALF_VALUE));
      push_sample(16'sd1, DELAY_BITS'(ONE_VALUE));
      push_sample(16'sd12345, {DELAY_BITS{1'b1}});
      push_sample(-16'sd20000, DELAY_BITS'(MAX_LENGTH * ONE_VALUE));
      push_sample(16'sd0, DELAY_BITS'(ONE_VALUE + HALF_VALUE - 1));
      push_sample(16'sd100, DELAY_BITS'(ONE_VALUE + HALF_VALUE + 1));
   endtask

   task automatic test_length_limits();
      set_line_length('0);
      push_sample(16'sd30000, DELAY_BITS'(300));
      push_sample(-16'sd30000, DELAY_BITS'(1));
      set_line_length({LENGTH_BITS{1'b1}});
      push_sample(16'sd5, DELAY_BITS'(MAX_LENGTH * ONE_VALUE - 1));
   endtask

   task automatic test_length_shrink();
      // write position sits inside the new length, so writing goes on from it
      set_line_length(LENGTH_BITS'(3));
      push_sample(16'sd7000, DELAY_BITS'(2 * ONE_VALUE + HALF_VALUE));
      push_sample(-16'sd9000, DELAY_BITS'(3 * ONE_VALUE));
      push_sample(16'sd11000, DELAY_BITS'(200));
   endtask

   task automatic test_saturation();
      int i;
      set_line_length(LENGTH_BITS'(2));
      for (i = 0; i < 8; i++) begin
         if (i % 2 == 0) push_sample(16'sh7fff, DELAY_BITS'(ONE_VALUE + HALF_VALUE));
         else push_sample(16'sh8000, DELAY_BITS'(ONE_VALUE + HALF_VALUE));
      end
   endtask

   task automatic test_random_traffic();
      int phase, n;
      logic [LENGTH_BITS-1:0]        len_val;
      logic [DELAY_BITS-1:0]         d;
      logic signed [SAMPLE_BITS-1:0] s;
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: len_val = LENGTH_BITS'(1);
            1: len_val = LENGTH_BITS'(MAX_LENGTH);
            2: len_val = LENGTH_BITS'($urandom);
            5: len_val = LENGTH_BITS'($urandom_range(65, MAX_LENGTH));
            default: len_val = LENGTH_BITS'($urandom_range(2, 64));
         endcase
         set_line_length(len_val);
         no_idle = (phase % 4 == 3);
         for (n = 0; n < 65; n++) begin
            case ($urandom_range(0, 9))
               0: d = DELAY_BITS'($urandom);
               1: d = DELAY_BITS'($urandom_range(0, HALF_VALUE - 1));
               default: d = DELAY_BITS'($urandom_range(0, ring_len * ONE_VALUE + ONE_VALUE - 1));
            endcase
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 1) == 1) s = 16'sh7fff;
               else s = 16'sh8000;
            end else begin
               s = SAMPLE_BITS'($urandom);
            end
            push_sample(s, d);
         end
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("allpass_fractional_delay_line_core test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            fail_count++;
            if (mismatch_count < SHOW_LIMIT)
               $display("unexpected transaction: sample_out %0d", rsp_sample_out);
            mismatch_count++;
         end else begin
            if (rsp_sample_out !== expected_samples[0]) begin
               fail_count++;
               if (mismatch_count < SHOW_LIMIT)
                  $display("sample_out mismatch: expected %0d actual %0d",
                           expected_samples[0], rsp_sample_out);
               mismatch_count++;
            end
            void'(expected_samples.pop_front());
         end
         rsp_hold_left = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      int i;
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample_in     = '0;
      req_delay_samples = '0;
      rsp_stall         = 1'b0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      fail_count        = 0;
      mismatch_count    = 0;
      cycle_count       = 0;
      rsp_hold_left     = 0;
      no_idle           = 1'b0;
      for (i = 0; i < MAX_LENGTH; i++) ring_mem[i] = '0;
      ring_wr_pos = 0;
      ring_len    = MAX_LENGTH;
      last_out    = 0;
      prev_tap    = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_delay_clamps();
      test_length_limits();
      test_length_shrink();
      test_saturation();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("allpass_fractional_delay_line_core test passed");
      else
         $display("allpass_fractional_delay_line_core test failed");
      $finish;
   end

endmodule

`default_nettype wire
